// File: rtl/assert_macros.svh
// assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define BCSM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, checked during reset too
`define BCSM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/bcsm_pkg.sv
// package: constants, codes and types of the coordinate step minimizer
`default_nettype none
package bcsm_pkg;

    localparam int MAX_PARAMS = 8;
    localparam int PASS_LIMIT = 34 * MAX_PARAMS;
    localparam int PASS_W     = $clog2(PASS_LIMIT + 2);
    localparam int IDX_W      = 3;
    localparam int CNT_W      = 4;
    localparam int IN_W       = 200;
    localparam int OUT_W      = 104;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_OBJ   = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        R_IDLE     = 3'd0,
        R_INIT     = 3'd1,
        R_FIRST    = 3'd2,
        R_REVERSED = 3'd3,
        R_RUN      = 3'd4
    } resume_t;

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_ADV     = 13'b0000000000010,
        S_ADV_ADD = 13'b0000000000100,
        S_CHK     = 13'b0000000001000,
        S_DBL     = 13'b0000000010000,
        S_BND     = 13'b0000000100000,
        S_FIRST_A = 13'b0000001000000,
        S_FIRST_B = 13'b0000010000000,
        S_FIRST_C = 13'b0000100000000,
        S_IMP_A   = 13'b0001000000000,
        S_IMP_B   = 13'b0010000000000,
        S_FIN     = 13'b0100000000000,
        S_EMIT    = 13'b1000000000000
    } state_t;

    typedef enum logic {
        KIND_EVAL  = 1'b0,
        KIND_FINAL = 1'b1
    } kind_t;

endpackage
`default_nettype wire

// File: rtl/bounded_coordinate_step_minimizer_unit.sv
// top level: sequencer of the bounded coordinate step search
// Usage: load items (opcode 0) store a slot's start value, step, limit and bounds.
// A start item (opcode 1) answers with one evaluation run of n items, n being
// active_count clamped to 1..8, slot order, tlast on the last item.
// Each objective item (opcode 2) steps the search with one shared saturating
// adder under a one-hot sequencer and answers with another evaluation run
// (kind 0) or the final answer (kind 1). Objectives while idle are dropped.
// A load leaves s_tready high. A start is answered by its run of n items. An
// objective walks the slots pass by pass: a converged slot is only checked, a
// moved slot goes through the adder states (one adder use per cycle); then the
// run is sent. With inverted bounds the walk is cut after 273 passes.
// s_tready is low while an item is worked on or its run is being sent.
// Results leave through an output register: a stalled receiver holds the run,
// a new item is taken once its last item sits in the register.
// Reset is asynchronous: control state clears, active_count goes to 8,
// steps_before_growth to 10; slot contents are undefined until loaded.
`default_nettype none
module bounded_coordinate_step_minimizer_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // index, start_value, step, step_limit, lower, upper, objective, zero fill
    input  wire logic [199:0] s_tdata,
    // opcode
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // coord_index, coord_value, step_value, best_value, zero fill
    output logic [103:0]      m_tdata,
    // kind
    output logic [0:0]        m_tuser,
    output logic              m_tlast,
    input  wire logic         cfg_wr_en,
    input  wire logic [0:0]   cfg_index,
    input  wire logic [7:0]   cfg_data
);

    bcsm_pkg::state_t  state_reg, state_next;
    bcsm_pkg::resume_t resume_reg, resume_next, pend_reg, pend_next;

    logic signed [31:0] coord_mem [bcsm_pkg::MAX_PARAMS];
    logic signed [31:0] step_mem  [bcsm_pkg::MAX_PARAMS];
    logic        [30:0] limit_mem [bcsm_pkg::MAX_PARAMS];
    logic signed [31:0] lo_mem    [bcsm_pkg::MAX_PARAMS];
    logic signed [31:0] hi_mem    [bcsm_pkg::MAX_PARAMS];

    logic [bcsm_pkg::CNT_W-1:0]  slot_reg, slot_next, conv_reg, conv_next;
    logic [bcsm_pkg::PASS_W-1:0] pass_reg, pass_next;
    logic [7:0]                  run_reg, run_next;
    logic signed [31:0]          trial_reg, trial_next, tmp_reg, tmp_next;
    logic signed [31:0]          best_reg, best_next, obj_reg, obj_next;
    logic                        full_reg, full_next, hihit_reg, hihit_next;
    logic [bcsm_pkg::IDX_W-1:0]  emit_k_reg, emit_k_next;
    bcsm_pkg::kind_t             kind_reg, kind_next;
    logic [3:0]                  ac_reg;
    logic [7:0]                  sbg_reg;

    logic                        out_valid_reg, out_valid_next;
    logic [bcsm_pkg::IDX_W-1:0]  out_idx_reg;
    logic signed [31:0]          out_coord_reg, out_step_reg, out_best_reg;
    logic                        out_kind_reg, out_last_reg;
    logic                        out_load;

    logic [bcsm_pkg::CNT_W-1:0]  n_act;
    logic [bcsm_pkg::IDX_W-1:0]  rd_idx;
    logic signed [31:0]          cur_c, cur_s, cur_lo, cur_hi;
    logic [30:0]                 cur_lim;
    logic [31:0]                 mag_s, mag_t, satm_t, half_t, refl_mag;
    logic signed [33:0]          add_a, add_b;
    logic signed [31:0]          add_sum;
    logic                        coord_we, step_we, load_we, accept, constr;
    logic signed [31:0]          coord_wd, step_wd;
    bcsm_pkg::opcode_t           op;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == bcsm_pkg::S_IDLE);
    assign op       = bcsm_pkg::opcode_t'(s_tuser);
    assign load_we  = accept && (op == bcsm_pkg::OP_LOAD);

    assign n_act = (ac_reg == 4'd0) ? 4'd1 :
                   (ac_reg > 4'(bcsm_pkg::MAX_PARAMS)) ? 4'(bcsm_pkg::MAX_PARAMS) : ac_reg;

    assign rd_idx  = (state_reg == bcsm_pkg::S_EMIT) ? emit_k_reg
                                                     : slot_reg[bcsm_pkg::IDX_W-1:0];
    assign cur_c   = coord_mem[rd_idx];
    assign cur_s   = step_mem[rd_idx];
    assign cur_lim = limit_mem[rd_idx];
    assign cur_lo  = lo_mem[rd_idx];
    assign cur_hi  = hi_mem[rd_idx];
    assign constr  = (cur_lo != cur_hi);

    assign mag_s    = cur_s[31] ? 32'(-cur_s) : cur_s;
    assign mag_t    = trial_reg[31] ? 32'(-trial_reg) : trial_reg;
    assign satm_t   = mag_t[31] ? 32'h7fffffff : mag_t;
    assign half_t   = satm_t >> 1;
    assign refl_mag = full_reg ? satm_t : half_t;

    bcsm_sat_add u_add (
        .a   (add_a),
        .b   (add_b),
        .sum (add_sum)
    );

    always_comb
    begin
        state_next     = state_reg;
        resume_next    = resume_reg;
        pend_next      = pend_reg;
        slot_next      = slot_reg;
        conv_next      = conv_reg;
        pass_next      = pass_reg;
        run_next       = run_reg;
        trial_next     = trial_reg;
        tmp_next       = tmp_reg;
        best_next      = best_reg;
        obj_next       = obj_reg;
        full_next      = full_reg;
        hihit_next     = hihit_reg;
        emit_k_next    = emit_k_reg;
        kind_next      = kind_reg;
        add_a          = 34'(cur_c);
        add_b          = 34'(trial_reg);
        coord_we       = 1'b0;
        coord_wd       = add_sum;
        step_we        = 1'b0;
        step_wd        = add_sum;
        out_load       = 1'b0;
        unique case (state_reg)
            bcsm_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        bcsm_pkg::OP_START:
                        begin
                            resume_next = bcsm_pkg::R_INIT;
                            kind_next   = bcsm_pkg::KIND_EVAL;
                            emit_k_next = '0;
                            state_next  = bcsm_pkg::S_EMIT;
                        end
                        bcsm_pkg::OP_OBJ:
                        begin
                            obj_next  = s_tdata[193:162];
                            pass_next = '0;
                            unique case (resume_reg)
                                bcsm_pkg::R_INIT:
                                begin
                                    best_next  = s_tdata[193:162];
                                    slot_next  = '0;
                                    conv_next  = '0;
                                    state_next = bcsm_pkg::S_ADV;
                                end
                                bcsm_pkg::R_FIRST:
                                begin
                                    state_next = bcsm_pkg::S_FIRST_A;
                                end
                                bcsm_pkg::R_REVERSED, bcsm_pkg::R_RUN:
                                begin
                                    state_next = bcsm_pkg::S_IMP_A;
                                end
                                default:
                                begin
                                    state_next = bcsm_pkg::S_IDLE;
                                end
                            endcase
                        end
                        default:
                        begin
                            state_next = bcsm_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            bcsm_pkg::S_ADV:
            begin
                if (slot_reg < n_act)
                begin
                    if (mag_s < {1'b0, cur_lim})
                    begin
                        conv_next = conv_reg + 1'b1;
                        slot_next = slot_reg + 1'b1;
                    end
                    else
                    begin
                        trial_next = cur_s;
                        state_next = bcsm_pkg::S_ADV_ADD;
                    end
                end
                else if ((conv_reg >= n_act) ||
                         (pass_reg + 1'b1 > bcsm_pkg::PASS_W'(bcsm_pkg::PASS_LIMIT)))
                begin
                    resume_next = bcsm_pkg::R_IDLE;
                    kind_next   = bcsm_pkg::KIND_FINAL;
                    emit_k_next = '0;
                    state_next  = bcsm_pkg::S_EMIT;
                end
                else
                begin
                    slot_next = '0;
                    conv_next = '0;
                    pass_next = pass_reg + 1'b1;
                end
            end
            bcsm_pkg::S_ADV_ADD:
            begin
                coord_we   = 1'b1;
                full_next  = 1'b0;
                pend_next  = bcsm_pkg::R_FIRST;
                state_next = bcsm_pkg::S_CHK;
            end
            bcsm_pkg::S_CHK:
            begin
                if (constr && (cur_c < cur_lo))
                begin
                    step_we    = 1'b1;
                    step_wd    = refl_mag;
                    hihit_next = 1'b0;
                    state_next = bcsm_pkg::S_DBL;
                end
                else if (constr && (cur_c > cur_hi))
                begin
                    step_we    = 1'b1;
                    step_wd    = 32'(-refl_mag);
                    hihit_next = 1'b1;
                    state_next = bcsm_pkg::S_DBL;
                end
                else
                begin
                    resume_next = pend_reg;
                    kind_next   = bcsm_pkg::KIND_EVAL;
                    emit_k_next = '0;
                    state_next  = bcsm_pkg::S_EMIT;
                end
            end
            bcsm_pkg::S_DBL:
            begin
                add_a      = 34'(cur_s);
                add_b      = 34'(cur_s);
                tmp_next   = add_sum;
                state_next = bcsm_pkg::S_BND;
            end
            bcsm_pkg::S_BND:
            begin
                add_a    = 34'(hihit_reg ? cur_hi : cur_lo);
                add_b    = 34'(tmp_reg);
                coord_we = 1'b1;
                if (full_reg)
                begin
                    state_next = bcsm_pkg::S_FIN;
                end
                else
                begin
                    slot_next  = slot_reg + 1'b1;
                    state_next = bcsm_pkg::S_ADV;
                end
            end
            bcsm_pkg::S_FIRST_A:
            begin
                run_next = '0;
                if (obj_reg > best_reg)
                begin
                    add_a      = '0;
                    add_b      = -34'(trial_reg);
                    trial_next = add_sum;
                    step_we    = 1'b1;
                    state_next = bcsm_pkg::S_FIRST_B;
                end
                else
                begin
                    state_next = bcsm_pkg::S_IMP_A;
                end
            end
            bcsm_pkg::S_FIRST_B:
            begin
                add_a      = 34'(trial_reg);
                add_b      = 34'(trial_reg);
                tmp_next   = add_sum;
                state_next = bcsm_pkg::S_FIRST_C;
            end
            bcsm_pkg::S_FIRST_C:
            begin
                add_b      = 34'(tmp_reg);
                coord_we   = 1'b1;
                full_next  = 1'b0;
                pend_next  = bcsm_pkg::R_REVERSED;
                state_next = bcsm_pkg::S_CHK;
            end
            bcsm_pkg::S_IMP_A:
            begin
                if (obj_reg < best_reg)
                begin
                    if (run_reg == sbg_reg)
                    begin
                        add_a      = 34'(trial_reg);
                        add_b      = 34'(trial_reg);
                        run_next   = '0;
                        trial_next = add_sum;
                        step_we    = 1'b1;
                    end
                    else
                    begin
                        run_next = run_reg + 1'b1;
                    end
                    best_next  = obj_reg;
                    state_next = bcsm_pkg::S_IMP_B;
                end
                else
                begin
                    state_next = bcsm_pkg::S_FIN;
                end
            end
            bcsm_pkg::S_IMP_B:
            begin
                coord_we   = 1'b1;
                full_next  = 1'b1;
                pend_next  = bcsm_pkg::R_RUN;
                state_next = bcsm_pkg::S_CHK;
            end
            bcsm_pkg::S_FIN:
            begin
                add_b      = -34'(trial_reg);
                coord_we   = 1'b1;
                step_we    = 1'b1;
                step_wd    = $signed(cur_s + 32'(cur_s[31])) >>> 1;
                slot_next  = slot_reg + 1'b1;
                state_next = bcsm_pkg::S_ADV;
            end
            bcsm_pkg::S_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load = 1'b1;
                    if ({1'b0, emit_k_reg} == n_act - 1'b1)
                    begin
                        state_next = bcsm_pkg::S_IDLE;
                    end
                    else
                    begin
                        emit_k_next = emit_k_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = bcsm_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bcsm_pkg::S_IDLE;
            resume_reg    <= bcsm_pkg::R_IDLE;
            pend_reg      <= bcsm_pkg::R_IDLE;
            slot_reg      <= '0;
            conv_reg      <= '0;
            pass_reg      <= '0;
            run_reg       <= '0;
            trial_reg     <= '0;
            best_reg      <= '0;
            full_reg      <= 1'b0;
            hihit_reg     <= 1'b0;
            emit_k_reg    <= '0;
            kind_reg      <= bcsm_pkg::KIND_EVAL;
            ac_reg        <= 4'd8;
            sbg_reg       <= 8'd10;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            resume_reg    <= resume_next;
            pend_reg      <= pend_next;
            slot_reg      <= slot_next;
            conv_reg      <= conv_next;
            pass_reg      <= pass_next;
            run_reg       <= run_next;
            trial_reg     <= trial_next;
            best_reg      <= best_next;
            full_reg      <= full_next;
            hihit_reg     <= hihit_next;
            emit_k_reg    <= emit_k_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                if (cfg_index == 1'b0)
                begin
                    ac_reg <= cfg_data[3:0];
                end
                else
                begin
                    sbg_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tmp_reg <= tmp_next;
        obj_reg <= obj_next;
        if (out_load)
        begin
            out_idx_reg   <= emit_k_reg;
            out_coord_reg <= cur_c;
            out_step_reg  <= cur_s;
            out_best_reg  <= best_reg;
            out_kind_reg  <= kind_reg;
            out_last_reg  <= ({1'b0, emit_k_reg} == n_act - 1'b1);
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            coord_mem[s_tdata[2:0]] <= s_tdata[34:3];
            step_mem[s_tdata[2:0]]  <= s_tdata[66:35];
            limit_mem[s_tdata[2:0]] <= s_tdata[97:67];
            lo_mem[s_tdata[2:0]]    <= s_tdata[129:98];
            hi_mem[s_tdata[2:0]]    <= s_tdata[161:130];
        end
        else
        begin
            if (coord_we)
            begin
                coord_mem[rd_idx] <= coord_wd;
            end
            if (step_we)
            begin
                step_mem[rd_idx] <= step_wd;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_best_reg, out_step_reg, out_coord_reg, out_idx_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

// File: rtl/bcsm_sat_add.sv
// shared saturating adder: 34-bit signed operands, 32-bit saturated sum
`default_nettype none
module bcsm_sat_add (
    input  wire logic signed [33:0] a,
    input  wire logic signed [33:0] b,
    output logic signed [31:0]      sum
);

    logic signed [34:0] wide;

    always_comb
    begin
        wide = {a[33], a} + {b[33], b};
        if (wide > 35'sd2147483647)
        begin
            sum = 32'sh7fffffff;
        end
        else if (wide < -35'sd2147483648)
        begin
            sum = 32'sh80000000;
        end
        else
        begin
            sum = wide[31:0];
        end
    end

endmodule
`default_nettype wire

// File: rtl/bcsm_checker.sv
// port checker for the coordinate step minimizer, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module bcsm_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [1:0]   s_tuser,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [103:0] m_tdata,
    input wire logic         m_tlast
);

    `BCSM_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
    `BCSM_ASSERT(a_load_ready, s_tvalid && s_tready && s_tuser == bcsm_pkg::OP_LOAD |=> s_tready, "load did not return to ready")
    `BCSM_ASSERT(a_start_busy, s_tvalid && s_tready && s_tuser == bcsm_pkg::OP_START |=> !s_tready, "start did not begin a run")
    `BCSM_ASSERT(a_slot7_last, m_tvalid && m_tdata[2:0] == 3'd7 |-> m_tlast, "top slot not last in run")
    `BCSM_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !m_tvalid, "result valid in reset")

endmodule

bind bounded_coordinate_step_minimizer_unit bcsm_checker u_bcsm_checker (.*);
`default_nettype wire

// File: test/bounded_coordinate_step_minimizer_unit_check.sv
// checker: predicts each result run of the coordinate step search and compares transfers
module bounded_coordinate_step_minimizer_unit_check
    import bcsm_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [199:0] s_tdata,
    input  wire logic [1:0]   s_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [103:0] m_tdata,
    input  wire logic [0:0]   m_tuser,
    input  wire logic         m_tlast,
    input  wire logic         cfg_wr_en,
    input  wire logic [0:0]   cfg_index,
    input  wire logic [7:0]   cfg_data,
    output int                errors,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint POS_MAX = 64'sd2147483647;
    localparam longint NEG_MAX = -64'sd2147483648;

    typedef struct {
        kind_t       kind;
        logic [2:0]  idx;
        logic [31:0] coord;
        logic [31:0] step;
        logic [31:0] best;
        logic        last;
    } coord_item_t;

    coord_item_t coord_runs[$];

    longint  coord_val[MAX_PARAMS];
    longint  step_val[MAX_PARAMS];
    longint  limit_val[MAX_PARAMS];
    longint  lo_bound[MAX_PARAMS];
    longint  hi_bound[MAX_PARAMS];
    longint  best_obj;
    longint  trial;
    int      slot;
    int      conv_cnt;
    int      run_len;
    resume_t resume;
    int      act_reg;
    int      growth_reg;

    assign pending = coord_runs.size();

    function automatic longint sat(longint v);
        if (v > POS_MAX) return POS_MAX;
        if (v < NEG_MAX) return NEG_MAX;
        return v;
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint addsat(longint a, longint b);
        return sat(a + b);
    endfunction

    function automatic longint dbl(longint v);
        return sat(2 * v);
    endfunction

    function automatic longint sx32(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic int n_active();
        int n;
        n = act_reg;
        if (n < 1) n = 1;
        if (n > MAX_PARAMS) n = MAX_PARAMS;
        return n;
    endfunction

    function automatic bit bounded(int i);
        return lo_bound[i] != hi_bound[i];
    endfunction

    function automatic void push_run(kind_t k);
        coord_item_t it;
        int n;
        n = n_active();
        for (int j = 0; j < n; j++) begin
            it.kind  = k;
            it.idx   = j[2:0];
            it.coord = coord_val[j][31:0];
            it.step  = step_val[j][31:0];
            it.best  = best_obj[31:0];
            it.last  = (j + 1 == n);
            coord_runs.push_back(it);
        end
    endfunction

    function automatic bit bounce_halve(int i, longint d);
        if (!bounded(i)) return 0;
        if (coord_val[i] < lo_bound[i]) begin
            step_val[i] = sat(mag(d)) / 2;
            coord_val[i] = addsat(lo_bound[i], dbl(step_val[i]));
            return 1;
        end
        if (coord_val[i] > hi_bound[i]) begin
            step_val[i] = -(sat(mag(d)) / 2);
            coord_val[i] = addsat(hi_bound[i], dbl(step_val[i]));
            return 1;
        end
        return 0;
    endfunction

    function automatic void sweep();
        int passes;
        int n;
        int i;
        longint d;
        passes = 0;
        forever begin
            n = n_active();
            while (slot < n) begin
                i = slot;
                d = step_val[i];
                if (mag(d) < limit_val[i]) begin
                    conv_cnt++;
                    slot++;
                    continue;
                end
                trial = d;
                coord_val[i] = addsat(coord_val[i], d);
                if (bounce_halve(i, d)) begin
                    slot++;
                    continue;
                end
                resume = R_FIRST;
                push_run(KIND_EVAL);
                return;
            end
            passes++;
            if (conv_cnt >= n || passes > PASS_LIMIT) begin
                resume = R_IDLE;
                push_run(KIND_FINAL);
                return;
            end
            slot = 0;
            conv_cnt = 0;
        end
    endfunction

    function automatic void close_coord();
        if (slot < MAX_PARAMS) begin
            step_val[slot] = step_val[slot] / 2;
            coord_val[slot] = addsat(coord_val[slot], -trial);
        end
        slot++;
        sweep();
    endfunction

    function automatic void improve_step(longint f);
        int i;
        i = slot;
        if (i >= MAX_PARAMS) begin
            sweep();
            return;
        end
        if (f < best_obj) begin
            if (run_len == growth_reg) begin
                run_len = 0;
                trial = dbl(trial);
                step_val[i] = trial;
            end
            else
                run_len = (run_len + 1) & 8'hff;
            best_obj = f;
            coord_val[i] = addsat(coord_val[i], trial);
            if (bounded(i)) begin
                if (coord_val[i] < lo_bound[i]) begin
                    step_val[i] = sat(mag(trial));
                    coord_val[i] = addsat(lo_bound[i], dbl(step_val[i]));
                    close_coord();
                    return;
                end
                if (coord_val[i] > hi_bound[i]) begin
                    step_val[i] = -sat(mag(trial));
                    coord_val[i] = addsat(hi_bound[i], dbl(step_val[i]));
                    close_coord();
                    return;
                end
            end
            resume = R_RUN;
            push_run(KIND_EVAL);
            return;
        end
        close_coord();
    endfunction

    function automatic void first_step(longint f);
        int i;
        i = slot;
        if (i >= MAX_PARAMS) begin
            sweep();
            return;
        end
        run_len = 0;
        if (f > best_obj) begin
            trial = sat(-trial);
            step_val[i] = trial;
            coord_val[i] = addsat(coord_val[i], dbl(trial));
            if (bounce_halve(i, trial)) begin
                slot++;
                sweep();
                return;
            end
            resume = R_REVERSED;
            push_run(KIND_EVAL);
            return;
        end
        improve_step(f);
    endfunction

    function automatic void take_item(logic [1:0] op, logic [199:0] d);
        int idx;
        longint f;
        idx = d[2:0];
        f = sx32(d[193:162]);
        case (opcode_t'(op))
            OP_LOAD:
            begin
                coord_val[idx] = sx32(d[34:3]);
                step_val[idx]  = sx32(d[66:35]);
                limit_val[idx] = longint'(d[97:67]);
                lo_bound[idx]  = sx32(d[129:98]);
                hi_bound[idx]  = sx32(d[161:130]);
            end
            OP_START:
            begin
                resume = R_INIT;
                push_run(KIND_EVAL);
            end
            OP_OBJ:
            begin
                case (resume)
                    R_INIT:
                    begin
                        best_obj = f;
                        slot = 0;
                        conv_cnt = 0;
                        sweep();
                    end
                    R_FIRST:    first_step(f);
                    R_REVERSED,
                    R_RUN:      improve_step(f);
                    default:    ;
                endcase
            end
            default: ;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        coord_item_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PARAMS; i++)
            begin
                coord_val[i] = 0;
                step_val[i] = 0;
                limit_val[i] = 0;
                lo_bound[i] = 0;
                hi_bound[i] = 0;
            end
            best_obj = 0;
            trial = 0;
            slot = 0;
            conv_cnt = 0;
            run_len = 0;
            resume = R_IDLE;
            act_reg = 8;
            growth_reg = 10;
            errors = 0;
            coord_runs.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (coord_runs.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    errors++;
                end
                else
                begin
                    want = coord_runs.pop_front();
                    if (m_tuser[0] !== want.kind)
                    begin
                        $error("kind: expected %0d actual %0d", want.kind, m_tuser[0]);
                        errors++;
                    end
                    if (m_tdata[2:0] !== want.idx)
                    begin
                        $error("coord_index: expected %0d actual %0d", want.idx, m_tdata[2:0]);
                        errors++;
                    end
                    if (m_tdata[34:3] !== want.coord)
                    begin
                        $error("coord_value: expected %h actual %h", want.coord, m_tdata[34:3]);
                        errors++;
                    end
                    if (m_tdata[66:35] !== want.step)
                    begin
                        $error("step_value: expected %h actual %h", want.step, m_tdata[66:35]);
                        errors++;
                    end
                    if (m_tdata[98:67] !== want.best)
                    begin
                        $error("best_value: expected %h actual %h", want.best, m_tdata[98:67]);
                        errors++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %0d actual %0d", want.last, m_tlast);
                        errors++;
                    end
                end
            end
            if (cfg_wr_en)
            begin
                if (cfg_index == 1'b0)
                    act_reg = cfg_data[3:0];
                else
                    growth_reg = cfg_data;
            end
            if (s_tvalid && s_tready)
                take_item(s_tuser, s_tdata);
        end
    end

endmodule

// File: test/bounded_coordinate_step_minimizer_unit_test.sv
// testbench top: drives the coordinate step search with directed and random items
module bounded_coordinate_step_minimizer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import bcsm_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 64;
    localparam logic [31:0] Q_MAX = 32'h7fffffff;
    localparam logic [31:0] Q_MIN = 32'h80000000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [199:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_wr_en;
    logic [0:0]   cfg_index;
    logic [7:0]   cfg_data;
    int           errors;
    int           pending;
    int           cycles;
    bit           calm;
    logic [31:0]  obj_trend;

    bounded_coordinate_step_minimizer_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    bounded_coordinate_step_minimizer_unit_check u_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("bounded_coordinate_step_minimizer_unit_test: FAIL");
            $finish;
        end
    end

    // receiver stalls
    initial
    begin
        int n;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = calm ? 0 : $urandom_range(0, 3);
            if (n > 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic send(opcode_t op, logic [2:0] idx, logic [31:0] sv, logic [31:0] st,
                        logic [30:0] lim, logic [31:0] lo, logic [31:0] hi,
                        logic [31:0] obj);
        int n;
        n = calm ? 0 : $urandom_range(0, 3);
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, obj, hi, lo, lim, st, sv, idx};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_obj(logic [31:0] obj);
        send(OP_OBJ, 3'($urandom), $urandom, $urandom, 31'($urandom), $urandom, $urandom,
             obj);
    endtask

    task automatic send_ctl(opcode_t op);
        send(op, 3'($urandom), $urandom, $urandom, 31'($urandom), $urandom, $urandom,
             $urandom);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_cfg(logic [0:0] idx, logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // slot with a step that shrinks to its limit in a few halvings
    task automatic load_slot(logic [2:0] idx);
        logic [31:0] sv, st, lo, hi;
        logic [30:0] lim;
        int          shape;
        sv    = $urandom_range(0, 3) == 0 ? $urandom : {{15{$urandom_range(0, 1) == 1}},
                17'($urandom_range(0, 32'h1ffff))};
        st    = 32'd1 << $urandom_range(4, 20);
        lim   = 31'(st >> $urandom_range(0, 4));
        if ($urandom_range(0, 1)) st = -st;
        shape = $urandom_range(0, 9);
        if (shape < 3)
        begin
            lo = sv;
            hi = sv;
        end
        else if (shape < 8)
        begin
            lo = sv - $urandom_range(0, 32'h00080000);
            hi = sv + $urandom_range(1, 32'h00080000);
        end
        else
        begin
            lo  = $urandom;
            hi  = $urandom;
            lim = shape == 9 ? 31'($urandom) : lim;
        end
        send(OP_LOAD, idx, sv, st, lim, lo, hi, $urandom);
    endtask

    function automatic logic [31:0] next_obj();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            obj_trend = Q_MIN;
        else if (r == 1)
            obj_trend = Q_MAX;
        else if (r < 12)
            obj_trend = obj_trend - $urandom_range(0, 4000);
        else if (r < 15)
            obj_trend = obj_trend;
        else
            obj_trend = obj_trend + $urandom_range(1, 4000);
        return obj_trend;
    endfunction

    initial
    begin
        int r;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_NONE;
        cfg_wr_en = 1'b0;
        cfg_index = 1'b0;
        cfg_data  = 8'd0;
        cycles    = 0;
        calm      = 1'b0;
        obj_trend = 32'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, ignored items, restarts, reflection, inverted bounds
        write_cfg(1'b0, 8'd8);
        write_cfg(1'b1, 8'd0);
        send_ctl(OP_NONE);
        send_obj(32'd5);
        send(OP_LOAD, 3'd0, 32'h0, 32'h00010000, 31'h4000, 32'h0, 32'h0, 32'd0);
        send(OP_LOAD, 3'd1, 32'h0, 32'h00030000, 31'h4000, 32'hfffe0000, 32'h00020000,
             32'd0);
        send(OP_LOAD, 3'd2, Q_MAX, Q_MIN, 31'h7fffffff, 32'h5, 32'h5, 32'd0);
        send(OP_LOAD, 3'd3, Q_MIN, Q_MAX, 31'h40000000, Q_MIN, Q_MAX, 32'd0);
        send(OP_LOAD, 3'd4, Q_MAX, 32'h00100000, 31'h10000, 32'h0, Q_MAX, 32'd0);
        send(OP_LOAD, 3'd5, Q_MIN, 32'hfff00000, 31'h10000, Q_MIN, 32'h0, 32'd0);
        send(OP_LOAD, 3'd6, 32'h1234, 32'h8000, 31'h2000, 32'h00100000, 32'hfff00000,
             32'd0);
        send(OP_LOAD, 3'd7, 32'h0, 32'h00020000, 31'h10000, Q_MAX, Q_MIN, 32'd0);
        send_ctl(OP_START);
        send_obj(32'd100);
        send_obj(32'd50);
        send_obj(32'd10);
        send_obj(32'd10);
        send_obj(Q_MAX);
        send_ctl(OP_START);
        send_obj(Q_MIN);
        send(OP_LOAD, 3'd0, 32'h0, 32'hffff0000, 31'h4000, 32'h0, 32'h0, 32'd0);
        send_obj(Q_MIN);
        send_ctl(OP_NONE);
        for (int k = 0; k < 6; k++) send_obj(32'd200 - k);
        settle();

        // random phases with changing settings
        for (int ph = 0; ph < 12; ph++)
        begin
            calm = (ph % 4 == 3);
            case (ph)
                0:       write_cfg(1'b0, 8'd1);
                1:       write_cfg(1'b0, 8'd8);
                default: write_cfg(1'b0, 8'($urandom_range(1, 8)));
            endcase
            case (ph % 3)
                0:       write_cfg(1'b1, 8'd255);
                1:       write_cfg(1'b1, 8'd0);
                default: write_cfg(1'b1, 8'($urandom_range(0, 4)));
            endcase
            for (int k = 0; k < 8; k++) load_slot(3'(k));
            obj_trend = $urandom;
            send_ctl(OP_START);
            for (int k = 0; k < 24; k++)
            begin
                r = $urandom_range(0, 39);
                if (r == 0)
                    load_slot(3'($urandom_range(0, 7)));
                else if (r == 1)
                    send_ctl(OP_START);
                else if (r == 2)
                    send_ctl(OP_NONE);
                else
                    send_obj(next_obj());
            end
            settle();
        end

        settle();
        if (errors == 0 && pending == 0)
            $display("bounded_coordinate_step_minimizer_unit_test: PASS");
        else
            $display("bounded_coordinate_step_minimizer_unit_test: FAIL");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/bcsm_pkg.sv
rtl/bcsm_sat_add.sv
rtl/bounded_coordinate_step_minimizer_unit.sv
rtl/bcsm_checker.sv
test/bounded_coordinate_step_minimizer_unit_check.sv
test/bounded_coordinate_step_minimizer_unit_test.sv
